[src/gtsp_pkg.sv]
// Shared types, widths and codes for the generation-tagged slot pool.
package gtsp_pkg;

	localparam int IDX_W    = 8;
	localparam int GEN_W    = 24;
	localparam int HANDLE_W = GEN_W + IDX_W;
	localparam int DEPTH    = 256;
	localparam int CNT_W    = 9;

	typedef logic [IDX_W-1:0]    idx_t;
	typedef logic [GEN_W-1:0]    gen_t;
	typedef logic [HANDLE_W-1:0] handle_t;
	typedef logic [CNT_W-1:0]    cnt_t;
	typedef logic [1:0]          status_t;

	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_EMPTY   = 2'd1;
	localparam status_t ST_INVALID = 2'd2;

	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	typedef struct packed {
		logic pop;
		logic push;
		idx_t push_idx;
	} fl_req_t;

	typedef struct packed {
		logic wr;
		logic set;
		idx_t idx;
		gen_t gen;
	} st_req_t;

endpackage

[src/gtsp_free_list.sv]
// Free-slot FIFO held in a synchronous memory, with a fill count for reset contents.
module gtsp_free_list import gtsp_pkg::*; #(
	parameter int SLOTS = 256
) (
	input  logic    clk,
	input  logic    arst_n,
	input  fl_req_t req,
	output idx_t    head_idx,
	output logic    empty
);

	localparam idx_t TAIL0 = idx_t'(SLOTS % DEPTH);
	localparam cnt_t CNT0  = cnt_t'(SLOTS);
	localparam cnt_t FULL  = cnt_t'(DEPTH);

	idx_t fifo_mem [DEPTH];
	idx_t rd_data_s1;
	idx_t head_q;
	idx_t tail_q;
	cnt_t count_q;
	cnt_t pushed_q;
	idx_t offset;
	logic written;
	logic push_eff;

	assign push_eff = req.push && (count_q != FULL);
	assign offset   = idx_t'(head_q - TAIL0);
	assign written  = pushed_q > {1'b0, offset};
	assign head_idx = written ? rd_data_s1 : head_q;
	assign empty    = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push_eff) begin
			fifo_mem[tail_q] <= req.push_idx;
		end
		rd_data_s1 <= fifo_mem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= TAIL0;
			count_q  <= CNT0;
			pushed_q <= '0;
		end else begin
			if (req.pop) begin
				head_q <= idx_t'(head_q + 1'b1);
			end
			if (push_eff) begin
				tail_q <= idx_t'(tail_q + 1'b1);
				if (pushed_q != FULL) begin
					pushed_q <= cnt_t'(pushed_q + 1'b1);
				end
			end
			count_q <= cnt_t'(count_q + cnt_t'(push_eff) - cnt_t'(req.pop));
		end
	end

endmodule

[src/gtsp_slot_table.sv]
// Per-slot generation store: synchronous memory plus valid bits cleared at reset.
module gtsp_slot_table import gtsp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  idx_t    rd_addr,
	input  st_req_t req,
	output gen_t    rd_gen
);

	gen_t             gen_mem [DEPTH];
	gen_t             rd_s1;
	logic             vld_s1;
	logic [DEPTH-1:0] vld_q;

	assign rd_gen = vld_s1 ? rd_s1 : '0;

	always_ff @(posedge clk) begin
		if (req.wr && req.set) begin
			gen_mem[req.idx] <= req.gen;
		end
		rd_s1  <= gen_mem[rd_addr];
		vld_s1 <= vld_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (req.wr) begin
			vld_q[req.idx] <= req.set;
		end
	end

endmodule

[src/generation_tagged_slot_pool.sv]
// Top level of the generation-tagged slot pool: command control and result register.
//
// Usage:
//   Command channel: drive op and handle_in with start high; the item is taken at
//   the rising edge where start is high and busy is low. op selects allocate or
//   release; handle_in matters only for a release.
//   Result channel: done is high for exactly one cycle with status, handle_out
//   and slot_index valid; the receiver cannot stall, so it must take it then.
// Timing:
//   For each item, the accept cycle issues the free-list and slot-table
//   memory reads, and the next cycle (busy high) checks the read data and writes back.
//   done is registered from that write-back cycle, and a new item may be accepted
//   once busy falls, also while done is shown.
//   The registered reads of the two memories set this split of the work.
// Reset:
//   arst_n low returns the free list to slots 0..SLOTS-1 in order, marks every
//   slot free and zeroes the generation counter. No clearing pass is needed;
//   the block accepts items from the first cycle after reset.
module generation_tagged_slot_pool import gtsp_pkg::*; #(
	parameter int SLOTS = 256
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  logic    op,
	input  handle_t handle_in,
	output logic    done,
	output status_t status,
	output handle_t handle_out,
	output idx_t    slot_index
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;
	localparam cnt_t SLOT_LIM = cnt_t'(SLOTS);

	logic    state_q;
	logic    op_q;
	handle_t handle_q;
	gen_t    gen_q;
	logic    done_q;
	status_t status_q;
	handle_t handle_out_q;
	idx_t    slot_index_q;

	logic    accept;
	logic    exec;
	logic    empty;
	idx_t    head_idx;
	gen_t    stored_gen;
	gen_t    gen_inc;
	gen_t    gen_next;
	idx_t    rel_idx;
	gen_t    rel_gen;
	logic    alloc_ok;
	logic    rel_ok;
	fl_req_t fl_req;
	st_req_t st_req;

	assign busy   = (state_q == S_EXEC);
	assign exec   = busy;
	assign accept = start && !busy;

	assign rel_idx  = handle_q[IDX_W-1:0];
	assign rel_gen  = handle_q[HANDLE_W-1:IDX_W];
	assign gen_inc  = gen_t'(gen_q + 1'b1);
	assign gen_next = (gen_inc == '0) ? gen_t'(1) : gen_inc;

	assign alloc_ok = (op_q == OP_ALLOC) && !empty;
	assign rel_ok   = (op_q == OP_RELEASE) && (rel_gen != '0) && !handle_q[HANDLE_W-1]
		&& ({1'b0, rel_idx} < SLOT_LIM) && (stored_gen == rel_gen);

	assign fl_req.pop      = exec && alloc_ok;
	assign fl_req.push     = exec && rel_ok;
	assign fl_req.push_idx = rel_idx;

	assign st_req.wr  = exec && (alloc_ok || rel_ok);
	assign st_req.set = alloc_ok;
	assign st_req.idx = alloc_ok ? head_idx : rel_idx;
	assign st_req.gen = gen_next;

	gtsp_free_list #(
		.SLOTS(SLOTS)
	) u_free_list (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (fl_req),
		.head_idx(head_idx),
		.empty   (empty)
	);

	gtsp_slot_table u_slot_table (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_addr(handle_in[IDX_W-1:0]),
		.req    (st_req),
		.rd_gen (stored_gen)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			gen_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= exec;
			if (accept) begin
				state_q <= S_EXEC;
			end else if (exec) begin
				state_q <= S_IDLE;
			end
			if (exec && alloc_ok) begin
				gen_q <= gen_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= op;
			handle_q <= handle_in;
		end
		if (exec) begin
			if (alloc_ok) begin
				status_q     <= ST_OK;
				handle_out_q <= {gen_next, head_idx};
				slot_index_q <= head_idx;
			end else if (rel_ok) begin
				status_q     <= ST_OK;
				handle_out_q <= '0;
				slot_index_q <= rel_idx;
			end else begin
				status_q     <= (op_q == OP_ALLOC) ? ST_EMPTY : ST_INVALID;
				handle_out_q <= '0;
				slot_index_q <= '0;
			end
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign handle_out = handle_out_q;
	assign slot_index = slot_index_q;

endmodule
